/* hw/rtl/vmc_pkg.sv */
// vmc_pkg: shared types and constants of the interpreter machine
// holds command codes, fault codes and ALU operation codes
// no dependencies
`timescale 1ns / 1ps
package vmc_pkg;

  localparam int unsigned ADDR_W          = 12;
  localparam int unsigned MEM_DEPTH       = 4096;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned SCREEN_W        = 64;
  localparam int unsigned SCREEN_H        = 32;
  localparam logic [ADDR_W-1:0] START_DEF = 12'h200;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_EXEC = 2'd1,
    CMD_TICK = 2'd2,
    CMD_ROW  = 2'd3
  } cmd_e;

  localparam logic [1:0] FLT_NONE      = 2'd0;
  localparam logic [1:0] FLT_OPCODE    = 2'd1;
  localparam logic [1:0] FLT_OVERFLOW  = 2'd2;
  localparam logic [1:0] FLT_UNDERFLOW = 2'd3;

  typedef enum logic [2:0] {
    ALU_PASSB,
    ALU_OR,
    ALU_AND,
    ALU_XOR,
    ALU_ADD,
    ALU_SUB,
    ALU_SHR
  } alu_op_e;

endpackage

/* hw/rtl/vm_cpu_with_sprite_display.sv */
// vm_cpu_with_sprite_display: interpreter machine top level
// one request at a time; the memory port and the shared ALU set the step count
// reset: clearing pass over main memory, no request taken meanwhile
// depends on vmc_pkg, vmc_ram, vmc_alu
`timescale 1ns / 1ps
module vm_cpu_with_sprite_display import vmc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [15:0] keys_i,
  input  logic [7:0]  random_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] program_counter_o,
  output logic [63:0] row_pixels_o,
  output logic        redraw_o,
  output logic        waiting_key_o,
  output logic [1:0]  fault_o
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW  = $clog2(SCREEN_H);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FETCH0, S_FETCH1, S_FETCH2, S_RDX, S_RDY, S_EXEC,
    S_FLAG, S_RET, S_BCD_H, S_BCD_T, S_BCD_W, S_DRAW_RD, S_DRAW_WR,
    S_STORE, S_LOAD_RD, S_LOAD_WR, S_ROW, S_RESP
  } state_e;

  state_e state_q;

  logic [ADDR_W-1:0] start_q, pc_q, idx_q, clr_q;
  logic [SPW-1:0]    sp_q;
  logic [7:0]        v_q [16];
  logic [63:0]       fb_q [SCREEN_H];
  logic [7:0]        dt_q, st_q;
  logic [15:0]       op_q;
  logic [7:0]        va_q, vb_q, bcd_q;
  logic [1:0]        hund_q;
  logic [3:0]        tens_q, cnt_q;
  logic [1:0]        widx_q;
  logic              flag_q, hit_q;
  logic [ADDR_W-1:0] addr_q;
  logic [15:0]       keys_q;
  logic [7:0]        rnd_q;
  logic              res_redraw_q, res_wait_q;
  logic [1:0]        res_fault_q;
  logic [63:0]       res_row_q;
  logic              out_valid_q;

  // handshake and configuration port
  logic in_acc, cfg_wr;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign cfg_wr     = psel & penable & pwrite & ~paddr[2];
  assign pready     = 1'b1;
  assign prdata     = paddr[2] ? 32'd0 : {20'd0, start_q};
  assign out_valid_o = out_valid_q;

  // instruction fields
  logic [3:0]        op_x, op_y, op_n;
  logic [7:0]        op_nn;
  logic [ADDR_W-1:0] op_nnn, nxt, nxt2;
  assign op_x   = op_q[11:8];
  assign op_y   = op_q[7:4];
  assign op_n   = op_q[3:0];
  assign op_nn  = op_q[7:0];
  assign op_nnn = op_q[11:0];
  assign nxt    = pc_q + 12'd2;
  assign nxt2   = pc_q + 12'd4;

  // register file read port for the x, y and store-loop operands
  logic [3:0] vrd_idx;
  logic [7:0] vrd;
  always_comb begin
    unique case (state_q)
      S_RDX:   vrd_idx = op_x;
      S_RDY:   vrd_idx = op_y;
      default: vrd_idx = cnt_q;
    endcase
  end
  assign vrd = v_q[vrd_idx];

  // shared ALU operand selection
  alu_op_e    alu_op;
  logic [7:0] alu_a, alu_b, alu_res;
  logic       alu_flag;
  always_comb begin
    alu_op = ALU_XOR;
    alu_a  = va_q;
    alu_b  = vb_q;
    unique case (state_q)
      S_BCD_H: begin
        alu_op = ALU_SUB;
        alu_a  = bcd_q;
        alu_b  = 8'd100;
      end
      S_BCD_T: begin
        alu_op = ALU_SUB;
        alu_a  = bcd_q;
        alu_b  = 8'd10;
      end
      default: begin
        unique case (op_q[15:12])
          4'h3, 4'h4: alu_b = op_nn;
          4'h7: begin
            alu_op = ALU_ADD;
            alu_b  = op_nn;
          end
          4'h8: begin
            unique case (op_n)
              4'h0:    alu_op = ALU_PASSB;
              4'h1:    alu_op = ALU_OR;
              4'h2:    alu_op = ALU_AND;
              4'h4:    alu_op = ALU_ADD;
              4'h5:    alu_op = ALU_SUB;
              4'h6:    alu_op = ALU_SHR;
              default: alu_op = ALU_XOR;
            endcase
          end
          default: alu_op = ALU_XOR;
        endcase
      end
    endcase
  end

  vmc_alu u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .flag_o (alu_flag)
  );

  // sprite row placement and framebuffer row read
  logic [RW-1:0] drow, fb_ridx;
  logic [63:0]   fb_row, spr_mask;
  logic [63:0]   spr_wide;
  logic [7:0]    mem_rdata;
  assign drow     = vb_q[RW-1:0] + {1'b0, cnt_q};
  assign fb_ridx  = (state_q == S_DRAW_WR) ? drow : addr_q[RW-1:0];
  assign fb_row   = fb_q[fb_ridx];
  assign spr_wide = {mem_rdata, 56'd0};
  assign spr_mask = (spr_wide >> va_q[5:0]) | (spr_wide << (7'd64 - {1'b0, va_q[5:0]}));

  // highest pressed key
  logic [3:0] key_hi;
  always_comb begin
    key_hi = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (keys_q[k]) key_hi = 4'(k);
    end
  end

  logic key_down;
  assign key_down = (va_q[7:4] == 4'd0) & keys_q[va_q[3:0]];

  // main memory port selection
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 8'd0;
    mem_raddr = pc_q;
    unique case (state_q)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        if (in_acc && cmd_e'(cmd_i) == CMD_LOAD) begin
          mem_we    = 1'b1;
          mem_waddr = address_i;
          mem_wdata = data_i;
        end
      end
      S_FETCH1:  mem_raddr = pc_q + 12'd1;
      S_DRAW_RD: mem_raddr = idx_q + {8'd0, cnt_q};
      S_LOAD_RD: mem_raddr = idx_q + {8'd0, cnt_q};
      S_BCD_W: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q + {10'd0, widx_q};
        unique case (widx_q)
          2'd0:    mem_wdata = {6'd0, hund_q};
          2'd1:    mem_wdata = {4'd0, tens_q};
          default: mem_wdata = bcd_q;
        endcase
      end
      S_STORE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q + {8'd0, cnt_q};
        mem_wdata = vrd;
      end
      default: mem_raddr = pc_q;
    endcase
  end

  vmc_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // return stack
  logic              stk_full, stk_we;
  logic [SPW-1:0]    sp_dec;
  logic [ADDR_W-1:0] stk_rdata;
  assign stk_full = (sp_q >= SPW'(STACK_DEPTH));
  assign sp_dec   = sp_q - SPW'(1);
  assign stk_we   = (state_q == S_EXEC) && (op_q[15:12] == 4'h2) && !stk_full;

  vmc_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sp_q[SAW-1:0]),
    .wdata_i (nxt),
    .raddr_i (sp_dec[SAW-1:0]),
    .rdata_o (stk_rdata)
  );

  // sequencer, machine state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      start_q      <= START_DEF;
      pc_q         <= START_DEF;
      idx_q        <= '0;
      clr_q        <= '0;
      sp_q         <= '0;
      dt_q         <= '0;
      st_q         <= '0;
      out_valid_q  <= 1'b0;
      res_redraw_q <= 1'b0;
      res_wait_q   <= 1'b0;
      res_fault_q  <= FLT_NONE;
      for (int i = 0; i < 16; i++) v_q[i] <= '0;
      for (int i = 0; i < SCREEN_H; i++) fb_q[i] <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_RESP) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 12'd1;
          if (clr_q == 12'hFFF) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            addr_q       <= address_i;
            keys_q       <= keys_i;
            rnd_q        <= random_value_i;
            res_redraw_q <= 1'b0;
            res_wait_q   <= 1'b0;
            res_fault_q  <= FLT_NONE;
            res_row_q    <= '0;
            unique case (cmd_e'(cmd_i))
              CMD_LOAD: state_q <= S_RESP;
              CMD_EXEC: state_q <= S_FETCH0;
              CMD_TICK: begin
                if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
                if (st_q != 8'd0) st_q <= st_q - 8'd1;
                state_q <= S_RESP;
              end
              default: state_q <= S_ROW;
            endcase
          end
        end
        S_FETCH0: state_q <= S_FETCH1;
        S_FETCH1: begin
          op_q[15:8] <= mem_rdata;
          state_q    <= S_FETCH2;
        end
        S_FETCH2: begin
          op_q[7:0] <= mem_rdata;
          state_q   <= S_RDX;
        end
        S_RDX: begin
          va_q    <= vrd;
          state_q <= S_RDY;
        end
        S_RDY: begin
          vb_q    <= vrd;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_RESP;
          pc_q    <= nxt;
          unique case (op_q[15:12])
            4'h0: begin
              if (op_q == 16'h00E0) begin
                for (int i = 0; i < SCREEN_H; i++) fb_q[i] <= '0;
                res_redraw_q <= 1'b1;
              end else if (op_q == 16'h00EE) begin
                pc_q <= pc_q;
                if (sp_q == '0) res_fault_q <= FLT_UNDERFLOW;
                else state_q <= S_RET;
              end else begin
                pc_q        <= pc_q;
                res_fault_q <= FLT_OPCODE;
              end
            end
            4'h1: pc_q <= op_nnn;
            4'h2: begin
              if (stk_full) begin
                pc_q        <= pc_q;
                res_fault_q <= FLT_OVERFLOW;
              end else begin
                sp_q <= sp_q + SPW'(1);
                pc_q <= op_nnn;
              end
            end
            4'h3, 4'h5: if (alu_res == 8'd0) pc_q <= nxt2;
            4'h4, 4'h9: if (alu_res != 8'd0) pc_q <= nxt2;
            4'h6: v_q[op_x] <= op_nn;
            4'h7: v_q[op_x] <= alu_res;
            4'h8: begin
              if (op_n <= 4'h6) begin
                v_q[op_x] <= alu_res;
                flag_q    <= alu_flag;
                if (op_n >= 4'h4) state_q <= S_FLAG;
              end else begin
                pc_q        <= pc_q;
                res_fault_q <= FLT_OPCODE;
              end
            end
            4'hA: idx_q <= op_nnn;
            4'hB: pc_q <= op_nnn + {4'd0, v_q[0]};
            4'hC: v_q[op_x] <= rnd_q & op_nn;
            4'hD: begin
              hit_q        <= 1'b0;
              cnt_q        <= '0;
              res_redraw_q <= 1'b1;
              state_q      <= S_DRAW_RD;
            end
            4'hE: begin
              if (op_nn == 8'h9E) begin
                if (key_down) pc_q <= nxt2;
              end else if (op_nn == 8'hA1) begin
                if (!key_down) pc_q <= nxt2;
              end else begin
                pc_q        <= pc_q;
                res_fault_q <= FLT_OPCODE;
              end
            end
            default: begin
              unique case (op_nn)
                8'h07: v_q[op_x] <= dt_q;
                8'h0A: begin
                  if (keys_q == 16'd0) begin
                    pc_q       <= pc_q;
                    res_wait_q <= 1'b1;
                  end else begin
                    v_q[op_x] <= {4'd0, key_hi};
                  end
                end
                8'h15: dt_q <= va_q;
                8'h18: st_q <= va_q;
                8'h1E: idx_q <= idx_q + {4'd0, va_q};
                8'h29: idx_q <= {2'd0, va_q, 2'd0} + {4'd0, va_q};
                8'h33: begin
                  bcd_q   <= va_q;
                  hund_q  <= '0;
                  tens_q  <= '0;
                  widx_q  <= '0;
                  state_q <= S_BCD_H;
                end
                8'h55: begin
                  cnt_q   <= '0;
                  state_q <= S_STORE;
                end
                8'h65: begin
                  cnt_q   <= '0;
                  state_q <= S_LOAD_RD;
                end
                default: begin
                  pc_q        <= pc_q;
                  res_fault_q <= FLT_OPCODE;
                end
              endcase
            end
          endcase
        end
        S_FLAG: begin
          v_q[15] <= {7'd0, flag_q};
          state_q <= S_RESP;
        end
        S_RET: begin
          pc_q    <= stk_rdata;
          sp_q    <= sp_dec;
          state_q <= S_RESP;
        end
        // digits by repeated subtraction on the shared ALU
        S_BCD_H: begin
          if (alu_flag) begin
            bcd_q  <= alu_res;
            hund_q <= hund_q + 2'd1;
          end else begin
            state_q <= S_BCD_T;
          end
        end
        S_BCD_T: begin
          if (alu_flag) begin
            bcd_q  <= alu_res;
            tens_q <= tens_q + 4'd1;
          end else begin
            state_q <= S_BCD_W;
          end
        end
        S_BCD_W: begin
          widx_q <= widx_q + 2'd1;
          if (widx_q == 2'd2) state_q <= S_RESP;
        end
        // one sprite row at a time: read address in S_DRAW_RD, xor into the framebuffer in S_DRAW_WR
        S_DRAW_RD: begin
          if (cnt_q == op_n) begin
            v_q[15] <= {7'd0, hit_q};
            state_q <= S_RESP;
          end else begin
            state_q <= S_DRAW_WR;
          end
        end
        S_DRAW_WR: begin
          if ((fb_row & spr_mask) != '0) hit_q <= 1'b1;
          fb_q[drow] <= fb_row ^ spr_mask;
          cnt_q      <= cnt_q + 4'd1;
          state_q    <= S_DRAW_RD;
        end
        S_STORE: begin
          if (cnt_q == op_x) begin
            idx_q   <= idx_q + {8'd0, op_x} + 12'd1;
            state_q <= S_RESP;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_LOAD_RD: state_q <= S_LOAD_WR;
        S_LOAD_WR: begin
          v_q[cnt_q] <= mem_rdata;
          if (cnt_q == op_x) begin
            idx_q   <= idx_q + {8'd0, op_x} + 12'd1;
            state_q <= S_RESP;
          end else begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= S_LOAD_RD;
          end
        end
        S_ROW: begin
          res_row_q <= fb_row;
          state_q   <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q       <= 1'b1;
            program_counter_o <= pc_q;
            row_pixels_o      <= res_row_q;
            redraw_o          <= res_redraw_q;
            waiting_key_o     <= res_wait_q;
            fault_o           <= res_fault_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // register write also loads the program counter
      if (cfg_wr) begin
        start_q <= pwdata[11:0];
        pc_q    <= pwdata[11:0];
      end
    end
  end

  // checks on sequencer and stack
  a_cfg_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> pc_q == $past(pwdata[11:0]))
    else $error("program counter not loaded by register write");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside response step");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("request taken during memory clearing");

endmodule

/* hw/rtl/vmc_ram.sv */
// vmc_ram: generic single write port, single read port RAM
// read data is registered; no dependencies
`timescale 1ns / 1ps
module vmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/vmc_alu.sv */
// vmc_alu: shared 8-bit arithmetic and logic unit with flag output
// depends on vmc_pkg
`timescale 1ns / 1ps
module vmc_alu import vmc_pkg::*; (
  input  alu_op_e    op_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  output logic [7:0] res_o,
  output logic       flag_o
);

  logic [8:0] sum;
  logic [8:0] diff;

  assign sum  = {1'b0, a_i} + {1'b0, b_i};
  assign diff = {1'b0, a_i} - {1'b0, b_i};

  // flag is carry for add, no-borrow for sub, shifted-out bit for shr
  always_comb begin
    res_o  = b_i;
    flag_o = 1'b0;
    unique case (op_i)
      ALU_PASSB: res_o = b_i;
      ALU_OR:    res_o = a_i | b_i;
      ALU_AND:   res_o = a_i & b_i;
      ALU_XOR:   res_o = a_i ^ b_i;
      ALU_ADD: begin
        res_o  = sum[7:0];
        flag_o = sum[8];
      end
      ALU_SUB: begin
        res_o  = diff[7:0];
        flag_o = ~diff[8];
      end
      ALU_SHR: begin
        res_o  = {1'b0, a_i[7:1]};
        flag_o = a_i[0];
      end
      default: res_o = b_i;
    endcase
  end

endmodule

/* test/tb_vm_cpu_with_sprite_display.sv */
// tb_vm_cpu_with_sprite_display: self-checking bench for the interpreter machine
// predicts every result in a scoreboard class and drives the block through plain tasks
// depends on vmc_pkg and vm_cpu_with_sprite_display
`timescale 1ns / 1ps
module tb_vm_cpu_with_sprite_display import vmc_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned N_ITEMS     = 1850;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned STK_DEPTH   = STACK_DEPTH_DEF;
  localparam logic [2:0]  REG_START   = 3'd0;

  // mismatch bits returned by the checker
  localparam int unsigned BAD_PC     = 0;
  localparam int unsigned BAD_ROW    = 1;
  localparam int unsigned BAD_REDRAW = 2;
  localparam int unsigned BAD_WAIT   = 3;
  localparam int unsigned BAD_FAULT  = 4;
  localparam int unsigned BAD_EMPTY  = 5;

  typedef struct packed {
    logic [11:0] pc;
    logic [63:0] row;
    logic        redraw;
    logic        waitk;
    logic [1:0]  fault;
  } vm_result_t;

  // machine predictor plus queue of results still owed by the block
  class vm_scoreboard;
    logic [7:0]  mem [MEM_DEPTH];
    logic [7:0]  vreg [16];
    logic [11:0] idx;
    logic [11:0] pc;
    logic [11:0] stk [STK_DEPTH];
    int unsigned sp;
    logic [7:0]  dtim, stim;
    logic [63:0] fb [SCREEN_H];
    vm_result_t  owed [$];
    int unsigned n_exec, n_fault, n_draw, n_wait;

    function new();
      foreach (mem[i]) mem[i] = '0;
      foreach (vreg[i]) vreg[i] = '0;
      foreach (fb[i]) fb[i] = '0;
      idx = '0; pc = START_DEF; sp = 0; dtim = '0; stim = '0;
    endfunction

    function void set_start(logic [11:0] a);
      pc = a;
    endfunction

    // executes the instruction at pc, returns the fault code
    function logic [1:0] exec_op(logic [15:0] keys, logic [7:0] rnd,
                                 output logic redraw, output logic waitk);
      logic [15:0] op;
      logic [11:0] nxt, nnn;
      logic [7:0]  nn, a, b, spr;
      logic [8:0]  sum;
      logic [3:0]  x, y, n;
      logic        hit, down;
      int unsigned rw, col;
      op = {mem[pc], mem[pc + 12'd1]};
      nxt = pc + 12'd2;
      x = op[11:8]; y = op[7:4]; n = op[3:0];
      nn = op[7:0]; nnn = op[11:0];
      a = vreg[x]; b = vreg[y];
      redraw = 1'b0; waitk = 1'b0;
      case (op[15:12])
        4'h0: begin
          if (op == 16'h00E0) begin
            foreach (fb[i]) fb[i] = '0;
            redraw = 1'b1;
          end else if (op == 16'h00EE) begin
            if (sp == 0) return FLT_UNDERFLOW;
            sp--;
            nxt = stk[sp];
          end else return FLT_OPCODE;
        end
        4'h1: nxt = nnn;
        4'h2: begin
          if (sp >= STK_DEPTH) return FLT_OVERFLOW;
          stk[sp] = nxt;
          sp++;
          nxt = nnn;
        end
        4'h3: if (a == nn) nxt = nxt + 12'd2;
        4'h4: if (a != nn) nxt = nxt + 12'd2;
        4'h5: if (a == b) nxt = nxt + 12'd2;
        4'h6: vreg[x] = nn;
        4'h7: vreg[x] = a + nn;
        4'h8: begin
          case (n)
            4'h0: vreg[x] = b;
            4'h1: vreg[x] = a | b;
            4'h2: vreg[x] = a & b;
            4'h3: vreg[x] = a ^ b;
            4'h4: begin
              sum = {1'b0, a} + {1'b0, b};
              vreg[x] = sum[7:0];
              vreg[15] = {7'd0, sum[8]};
            end
            4'h5: begin
              vreg[x] = a - b;
              vreg[15] = {7'd0, a >= b};
            end
            4'h6: begin
              vreg[x] = a >> 1;
              vreg[15] = {7'd0, a[0]};
            end
            default: return FLT_OPCODE;
          endcase
        end
        4'h9: if (a != b) nxt = nxt + 12'd2;
        4'hA: idx = nnn;
        4'hB: nxt = {4'd0, vreg[0]} + nnn;
        4'hC: vreg[x] = rnd & nn;
        4'hD: begin
          hit = 1'b0;
          for (int r = 0; r < n; r++) begin
            spr = mem[idx + 12'(r)];
            rw = (int'(b) + r) % SCREEN_H;
            for (int c = 0; c < 8; c++) begin
              if (spr[7-c]) begin
                col = (int'(a) + c) % SCREEN_W;
                if (fb[rw][63-col]) hit = 1'b1;
                fb[rw][63-col] = ~fb[rw][63-col];
              end
            end
          end
          vreg[15] = {7'd0, hit};
          redraw = 1'b1;
        end
        4'hE: begin
          down = (a < 8'd16) && keys[a[3:0]];
          if (nn == 8'h9E) begin
            if (down) nxt = nxt + 12'd2;
          end else if (nn == 8'hA1) begin
            if (!down) nxt = nxt + 12'd2;
          end else return FLT_OPCODE;
        end
        default: begin
          case (nn)
            8'h07: vreg[x] = dtim;
            8'h0A: begin
              if (keys == '0) begin
                nxt = pc;
                waitk = 1'b1;
              end else begin
                for (int i = 0; i < 16; i++) if (keys[i]) vreg[x] = 8'(i);
              end
            end
            8'h15: dtim = a;
            8'h18: stim = a;
            8'h1E: idx = idx + {4'd0, a};
            8'h29: idx = 12'({4'd0, a} * 12'd5);
            8'h33: begin
              mem[idx]          = a / 8'd100;
              mem[idx + 12'd1]  = (a / 8'd10) % 8'd10;
              mem[idx + 12'd2]  = a % 8'd10;
            end
            8'h55: begin
              for (int i = 0; i <= x; i++) mem[idx + 12'(i)] = vreg[i];
              idx = idx + {8'd0, x} + 12'd1;
            end
            8'h65: begin
              for (int i = 0; i <= x; i++) vreg[i] = mem[idx + 12'(i)];
              idx = idx + {8'd0, x} + 12'd1;
            end
            default: return FLT_OPCODE;
          endcase
        end
      endcase
      pc = nxt;
      return FLT_NONE;
    endfunction

    // accepted request: update the model and queue the owed result
    function void note_request(cmd_e cmd, logic [11:0] addr, logic [7:0] data,
                               logic [15:0] keys, logic [7:0] rnd);
      vm_result_t res;
      logic rd, wk;
      res = '0;
      case (cmd)
        CMD_LOAD: mem[addr] = data;
        CMD_EXEC: begin
          res.fault = exec_op(keys, rnd, rd, wk);
          res.redraw = rd;
          res.waitk = wk;
          n_exec++;
          if (res.fault != FLT_NONE) n_fault++;
          if (rd) n_draw++;
          if (wk) n_wait++;
        end
        CMD_TICK: begin
          if (dtim != 0) dtim--;
          if (stim != 0) stim--;
        end
        default: res.row = fb[addr[4:0]];
      endcase
      res.pc = pc;
      owed.push_back(res);
    endfunction

    // compares a result with the oldest owed one, returns a mask of bad fields
    function logic [5:0] check_result(vm_result_t got, output vm_result_t want);
      logic [5:0] bad;
      bad = '0;
      want = '0;
      if (owed.size() == 0) begin
        bad[BAD_EMPTY] = 1'b1;
        return bad;
      end
      want = owed.pop_front();
      bad[BAD_PC]     = got.pc !== want.pc;
      bad[BAD_ROW]    = got.row !== want.row;
      bad[BAD_REDRAW] = got.redraw !== want.redraw;
      bad[BAD_WAIT]   = got.waitk !== want.waitk;
      bad[BAD_FAULT]  = got.fault !== want.fault;
      return bad;
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  cmd_i;
  logic [11:0] address_i;
  logic [7:0]  data_i, random_value_i;
  logic [15:0] keys_i;
  logic        out_valid_o, out_stall_i;
  logic [11:0] program_counter_o;
  logic [63:0] row_pixels_o;
  logic        redraw_o, waiting_key_o;
  logic [1:0]  fault_o;

  vm_scoreboard sb;
  int unsigned  n_errors, n_sent, n_checked, cycles, hold_left, idle_left;
  bit           quiet, hold_req, hold_done;

  vm_cpu_with_sprite_display u_top (.*);

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    $display("mismatch %s at cycle %0d: got %h want %h", what, cycles, got, want);
  endtask

  // result side: checks accepted results and drives stall bursts
  always @(posedge clk_i) begin
    vm_result_t got, want;
    logic [5:0] bad;
    if (out_valid_o && !out_stall_i && rst_ni) begin
      got = '{program_counter_o, row_pixels_o, redraw_o, waiting_key_o, fault_o};
      bad = sb.check_result(got, want);
      n_checked++;
      if (bad[BAD_EMPTY]) report("unexpected result, pc", 64'(got.pc), 64'd0);
      if (bad[BAD_PC]) report("program_counter", 64'(got.pc), 64'(want.pc));
      if (bad[BAD_ROW]) report("row_pixels", got.row, want.row);
      if (bad[BAD_REDRAW]) report("redraw", 64'(got.redraw), 64'(want.redraw));
      if (bad[BAD_WAIT]) report("waiting_key", 64'(got.waitk), 64'(want.waitk));
      if (bad[BAD_FAULT]) report("fault", 64'(got.fault), 64'(want.fault));
    end
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (idle_left != 0) begin
      idle_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(19) == 0) begin
      idle_left = $urandom_range(15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one request through the valid/stall handshake, with an optional gap first
  task automatic send(cmd_e cmd, logic [11:0] addr, logic [7:0] data,
                      logic [15:0] keys, logic [7:0] rnd);
    int unsigned gap;
    gap = (quiet || $urandom_range(3) != 0) ? 0 : $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    address_i      <= addr;
    data_i         <= data;
    keys_i         <= keys;
    random_value_i <= rnd;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, addr, data, keys, rnd);
    n_sent++;
  endtask

  // places an instruction at the predicted pc and runs it
  task automatic run_op(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
    logic [11:0] at;
    at = sb.pc;
    send(CMD_LOAD, at, op[15:8], 16'($urandom), 8'($urandom));
    send(CMD_LOAD, at + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
    send(CMD_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
  endtask

  // waits until every owed result is back, then lets the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_start(logic [11:0] a);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_START;
    pwdata  <= {20'd0, a};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_start(a);
  endtask

  function automatic logic [15:0] rand_op();
    logic [15:0] op;
    op = 16'($urandom);
    case (op[15:12])
      4'h0: case ($urandom_range(3))
              0: op = 16'h00E0;
              1, 2: op = 16'h00EE;
              default: ;
            endcase
      4'hD: op[3:0] = ($urandom_range(3) == 0) ? op[3:0] : 4'($urandom_range(4));
      4'hE: if ($urandom_range(3) != 0) op[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
      4'hF: case ($urandom_range(10))
              0: op[7:0] = 8'h07;
              1: op[7:0] = 8'h0A;
              2: op[7:0] = 8'h15;
              3: op[7:0] = 8'h18;
              4: op[7:0] = 8'h1E;
              5: op[7:0] = 8'h29;
              6: op[7:0] = 8'h33;
              7: op[7:0] = 8'h55;
              8: op[7:0] = 8'h65;
              default: ;
            endcase
      default: ;
    endcase
    return op;
  endfunction

  function automatic logic [15:0] rand_keys();
    case ($urandom_range(3))
      0: return '0;
      1: return 16'h1 << $urandom_range(15);
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned pick;
    sb = new();
    n_errors = 0; n_sent = 0; n_checked = 0; cycles = 0; hold_left = 0; idle_left = 0;
    quiet = 1'b0; hold_req = 1'b0; hold_done = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; cmd_i = '0; address_i = '0; data_i = '0;
    keys_i = '0; random_value_i = '0; out_stall_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, alu flags, draws with wrap, keys, faults
    send(CMD_LOAD, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
    send(CMD_ROW, 12'hFFF, 8'h00, 16'h0000, 8'h00);
    run_op(16'h6FFF, '0, '0);
    run_op(16'h6E3F, '0, '0);
    run_op(16'h8FE4, '0, '0);
    run_op(16'h8EF5, '0, '0);
    run_op(16'h8EE6, '0, '0);
    run_op(16'hDEF3, '0, '0);
    run_op(16'hDEF3, '0, '0);
    run_op(16'hF00A, '0, '0);
    run_op(16'hF30A, 16'h8001, '0);
    run_op(16'hEF9E, 16'hFFFF, '0);
    run_op(16'h00EE, '0, '0);
    run_op(16'h8127, '0, '0);
    run_op(16'hCAF0, '0, 8'hFF);
    run_op(16'hFF33, '0, '0);
    send(CMD_ROW, 12'h01F, '0, '0, '0);
    drain();

    // address wrap phase: fetch straddles the top of memory
    write_start(12'hFFF);
    run_op(16'h1000, '0, '0);
    drain();
    write_start(12'h000);

    // random programs with noise, several start address settings
    while (n_sent < N_ITEMS) begin
      if (n_sent > N_ITEMS - 200) quiet = 1'b1;
      hold_req = (n_sent > 400);
      if (n_sent % 600 < 3 && n_sent > 100) begin
        drain();
        write_start(12'($urandom));
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
        repeat (18) run_op({4'h2, 12'($urandom)}, '0, '0);
      end else if (pick < 60) begin
        run_op(rand_op(), rand_keys(), 8'($urandom));
      end else if (pick < 68) begin
        send(CMD_TICK, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (pick < 78) begin
        send(CMD_ROW, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        send(CMD_LOAD, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        send(CMD_EXEC, 12'($urandom), 8'($urandom), rand_keys(), 8'($urandom));
      end
    end
    drain();

    $display("covered %0d requests, %0d instructions (%0d faults, %0d draws, %0d key waits)",
             n_sent, sb.n_exec, sb.n_fault, sb.n_draw, sb.n_wait);
    $display("checked %0d results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
